// ===== rtl/ctw_pkg.sv =====
// Shared types and constants for the text console cell writer.
`default_nettype none
package ctw_pkg;

    // item kinds
    localparam logic [1:0] OP_PRINT = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_SET   = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    // control characters
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_BLANK = 8'h20;

    localparam int         TAB_STEP     = 4;
    localparam logic [7:0] ATTR_DEFAULT = 8'h0F;

    typedef struct packed {
        logic [7:0] row_in;
        logic [7:0] col_in;
        logic [3:0] bg;
        logic [3:0] fg;
        logic       use_color;
        logic [7:0] char_code;
        logic [1:0] op;
    } ctw_item_t;

    // what one print or cursor step asks of the store
    typedef struct packed {
        logic       wr_en;
        logic [7:0] wr_code;
        logic       scroll;
    } ctw_step_t;

endpackage
`default_nettype wire

// ===== rtl/text_console_cell_writer.sv =====
// Text console cell writer: sequencer, output register and cell store.
//
//  channel   dir  handshake               payload
//  s_        in   s_tvalid / s_tready     s_tuser op, s_tdata item fields
//  m_        out  m_tvalid / m_tready     m_tdata cursor, cell, scrolled
//  cfg_      in   cfg_valid / cfg_ready   cfg_data default attribute
//
// Print and set cursor finish in S_EXEC; read cell finishes in S_READ,
// after the registered RAM read. Clear sweeps the store one cell a cycle.
// A print that scrolls copies the store one cell a cycle with one read
// and one write port.
// The store needs no clearing after reset; cursor resets to (0,0).
// A result waiting on m_tready does not block the next item until that
// item itself has a result to hand over.
`default_nettype none
module text_console_cell_writer #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] char_code, [8] use_color, [12:9] fg, [16:13] bg,
    // [24:17] col_in, [32:25] row_in
    input  logic [39:0] s_tdata,
    // [1:0] op
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] cursor_col, [15:8] cursor_row, [31:16] cell_data, [32] scrolled
    output logic [39:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);
    import ctw_pkg::*;

    localparam int CELLS  = ROWS * COLS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W  = $clog2(CELLS + 1);
    localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(CELLS - 1);
    localparam logic [CNT_W-1:0] CNT_END   = CNT_W'(CELLS);
    localparam logic [CNT_W-1:0] CNT_MOVE  = CNT_W'((ROWS - 1) * COLS);
    localparam logic [CNT_W-1:0] CNT_COLS  = CNT_W'(COLS);
    localparam logic [7:0]       ROW_MAX   = 8'(ROWS - 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_CLEAR  = 3'd3;
    localparam logic [2:0] S_SCROLL = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next, cnt_m1, cnt_rd;
    ctw_item_t        item_reg;
    logic [7:0]       attr_cfg_reg;
    logic [15:0]      cell_res_reg;
    logic             scrolled_reg;
    logic             m_tvalid_reg;
    logic [39:0]      m_tdata_reg;

    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [15:0]       ram_wdata, ram_rdata;

    logic              commit, fin, out_free;
    logic [7:0]        item_attr, cur_col, cur_row;
    logic [ADDR_W-1:0] cell_addr;
    ctw_step_t         step;
    logic [15:0]       res_cell;
    logic              res_scrolled;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign commit    = (state_reg == S_EXEC);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign item_attr = item_reg.use_color ? {item_reg.bg, item_reg.fg} : attr_cfg_reg;
    assign cnt_m1    = cnt_reg - 1'b1;
    assign cnt_rd    = cnt_reg + CNT_COLS;

    ctw_cursor #(
        .COLS   (COLS),
        .ROWS   (ROWS),
        .ADDR_W (ADDR_W)
    ) u_cursor (
        .aclk    (aclk),
        .aresetn (aresetn),
        .commit  (commit),
        .item    (item_reg),
        .col_o   (cur_col),
        .row_o   (cur_row),
        .addr_o  (cell_addr),
        .step_o  (step)
    );

    ctw_ram #(
        .WIDTH  (16),
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        fin        = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_waddr  = cell_addr;
        ram_raddr  = cell_addr;
        ram_wdata  = {item_attr, step.wr_code};

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                cnt_next = '0;
                case (item_reg.op)
                    OP_READ: begin
                        ram_re     = 1'b1;
                        state_next = S_READ;
                    end
                    OP_CLEAR: begin
                        state_next = S_CLEAR;
                    end
                    OP_PRINT: begin
                        ram_we = step.wr_en;
                        if (step.scroll) begin
                            state_next = S_SCROLL;
                        end else begin
                            fin = 1'b1;
                        end
                    end
                    default: begin
                        fin = 1'b1;
                    end
                endcase
            end
            S_READ: begin
                fin = 1'b1;
            end
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg[ADDR_W-1:0];
                ram_wdata = {attr_cfg_reg, CH_BLANK};
                cnt_next  = cnt_reg + 1'b1;
                fin       = (cnt_reg == CNT_LAST);
            end
            S_SCROLL: begin
                // read one row ahead, write the cell fetched last cycle
                ram_re    = (cnt_reg < CNT_MOVE);
                ram_raddr = cnt_rd[ADDR_W-1:0];
                ram_we    = (cnt_reg != '0);
                ram_waddr = cnt_m1[ADDR_W-1:0];
                ram_wdata = (cnt_m1 < CNT_MOVE) ? ram_rdata : {item_attr, CH_BLANK};
                cnt_next  = cnt_reg + 1'b1;
                fin       = (cnt_reg == CNT_END);
            end
            S_DONE: begin
                fin = 1'b1;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (fin) begin
            state_next = out_free ? S_IDLE : S_DONE;
        end

        res_cell     = (state_reg == S_READ) ? ram_rdata
                     : (state_reg == S_EXEC) ? 16'd0 : cell_res_reg;
        res_scrolled = (state_reg != S_EXEC) && scrolled_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            attr_cfg_reg <= ATTR_DEFAULT;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                attr_cfg_reg <= cfg_data;
            end
            if (fin && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        if (s_tvalid && s_tready) begin
            item_reg <= '{row_in: s_tdata[32:25], col_in: s_tdata[24:17],
                          bg: s_tdata[16:13], fg: s_tdata[12:9],
                          use_color: s_tdata[8], char_code: s_tdata[7:0],
                          op: s_tuser};
        end
        if (state_reg == S_EXEC) begin
            cell_res_reg <= 16'd0;
            scrolled_reg <= step.scroll && (item_reg.op == OP_PRINT);
        end else if (state_reg == S_READ) begin
            cell_res_reg <= ram_rdata;
        end
        if (fin && out_free) begin
            m_tdata_reg <= {7'd0, res_scrolled, res_cell, cur_row, cur_col};
        end
    end

    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg == S_EXEC)
        else $error("accepted item not executed");

    a_ram_ports: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we && ram_re |-> ram_waddr != ram_raddr)
        else $error("read and write hit the same cell");

    a_scroll_row: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SCROLL |-> cur_row == ROW_MAX)
        else $error("scroll with cursor off the last row");

    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        fin && !out_free |=> state_reg == S_DONE && m_tvalid)
        else $error("result lost while output stalled");

endmodule
`default_nettype wire

// ===== rtl/ctw_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module ctw_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/ctw_cursor.sv =====
// Cursor registers, print/cursor stepping and cell address generation.
`default_nettype none
module ctw_cursor #(
    parameter int COLS   = 80,
    parameter int ROWS   = 25,
    parameter int ADDR_W = 11
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                commit,
    input  ctw_pkg::ctw_item_t  item,
    output logic [7:0]          col_o,
    output logic [7:0]          row_o,
    output logic [ADDR_W-1:0]   addr_o,
    output ctw_pkg::ctw_step_t  step_o
);
    import ctw_pkg::*;

    localparam logic [7:0] COL_MAX = 8'(COLS - 1);
    localparam logic [7:0] ROW_MAX = 8'(ROWS - 1);

    logic [7:0] col_reg, row_reg;
    logic [8:0] col_next, row_next;
    logic [7:0] col_cl, row_cl, wcol, a_col, a_row;

    always_comb begin
        col_cl   = (item.col_in > COL_MAX) ? COL_MAX : item.col_in;
        row_cl   = (item.row_in > ROW_MAX) ? ROW_MAX : item.row_in;
        col_next = {1'b0, col_reg};
        row_next = {1'b0, row_reg};
        wcol     = col_reg;
        step_o   = '{wr_en: 1'b0, wr_code: item.char_code, scroll: 1'b0};

        case (item.op)
            OP_PRINT: begin
                case (item.char_code)
                    CH_NL: begin
                        col_next = 9'd0;
                        row_next = {1'b0, row_reg} + 9'd1;
                    end
                    CH_TAB: begin
                        col_next = ({1'b0, col_reg} + 9'(TAB_STEP)) & ~9'(TAB_STEP - 1);
                    end
                    CH_CR: begin
                        col_next = 9'd0;
                    end
                    CH_BS: begin
                        if (col_reg != 8'd0) begin
                            col_next       = {1'b0, col_reg} - 9'd1;
                            wcol           = col_reg - 8'd1;
                            step_o.wr_en   = 1'b1;
                            step_o.wr_code = CH_BLANK;
                        end
                    end
                    default: begin
                        step_o.wr_en = 1'b1;
                        col_next     = {1'b0, col_reg} + 9'd1;
                    end
                endcase
                if (col_next >= 9'(COLS)) begin
                    col_next = 9'd0;
                    row_next = row_next + 9'd1;
                end
                if (row_next >= 9'(ROWS)) begin
                    row_next      = {1'b0, ROW_MAX};
                    step_o.scroll = 1'b1;
                end
            end
            OP_CLEAR: begin
                col_next = 9'd0;
                row_next = 9'd0;
            end
            OP_SET: begin
                col_next = {1'b0, col_cl};
                row_next = {1'b0, row_cl};
            end
            default: begin
            end
        endcase

        // a read addresses the requested cell, a print the cell under the cursor (backspace: the cell left of it)
        a_col  = (item.op == OP_READ) ? col_cl : wcol;
        a_row  = (item.op == OP_READ) ? row_cl : row_reg;
        addr_o = ADDR_W'(32'(a_row) * 32'(COLS) + 32'(a_col));

        col_o = commit ? col_next[7:0] : col_reg;
        row_o = commit ? row_next[7:0] : row_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= 8'd0;
            row_reg <= 8'd0;
        end else if (commit) begin
            col_reg <= col_next[7:0];
            row_reg <= row_next[7:0];
        end
    end

    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        col_reg <= COL_MAX && row_reg <= ROW_MAX)
        else $error("cursor left the screen");

    a_scroll_last_row: assert property (@(posedge aclk) disable iff (!aresetn)
        commit && step_o.scroll |=> row_reg == ROW_MAX && col_reg == 8'd0)
        else $error("scroll did not park cursor at start of last row");

    a_write_in_print: assert property (@(posedge aclk) disable iff (!aresetn)
        step_o.wr_en |-> item.op == OP_PRINT)
        else $error("cell write outside print");

endmodule
`default_nettype wire
